[hw/rtl/kpc_pkg.sv]
`default_nettype none

package kpc_pkg;

    // field widths fixed by the item format
    localparam int HELD_W   = 16;
    localparam int PERIOD_W = 7;
    localparam int PIN_W    = 4;
    localparam int IDX_W    = 3;
    localparam int MASK_W   = 4;
    localparam int CFG_W    = 16;
    localparam int REG_IDX_W = 2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS  = 2'd2;

    // register reset values
    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST = 7'd10;
    localparam logic [HELD_W-1:0]   DEBOUNCE_RST    = 16'd30;
    localparam logic [HELD_W-1:0]   LONG_PRESS_RST  = 16'd800;

    // request opcodes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_code_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] scan_period;
        logic [HELD_W-1:0]   debounce;
        logic [HELD_W-1:0]   long_press;
    } cfg_t;

    typedef struct packed {
        logic     ready;   // event pending after this request
        ev_code_t code;    // event returned by a read, else none
    } lane_status_t;

endpackage

`default_nettype wire

[hw/rtl/kpc_lane.sv]
`default_nettype none

module kpc_lane
    import kpc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         scan_en,
    input  wire logic         read_en,
    input  wire logic         pin_level,
    input  wire cfg_t         cfg,
    output lane_status_t      status
);

    logic              last_reg,  last_next;
    logic [HELD_W-1:0] held_reg,  held_next;
    ev_code_t          pend_reg,  pend_next;
    logic              ready_reg, ready_next;
    logic              long_reg,  long_next;

    logic              pressed;
    logic [HELD_W:0]   held_sum;
    logic [HELD_W-1:0] held_grown;

    assign pressed  = ~pin_level;
    assign held_sum = {1'b0, held_reg} + {{(HELD_W + 1 - PERIOD_W){1'b0}}, cfg.scan_period};

    always_comb
    begin
        held_grown = held_reg;
        if (last_reg)
        begin
            held_grown = held_sum[HELD_W] ? {HELD_W{1'b1}} : held_sum[HELD_W-1:0];
        end

        last_next  = last_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        ready_next = ready_reg;
        long_next  = long_reg;

        if (scan_en)
        begin
            held_next = held_grown;
            if (pressed && !last_reg)
            begin
                held_next = '0;
                long_next = 1'b0;
            end
            else if (!pressed && last_reg)
            begin
                // a hold that already gave a long event ends silently
                if (held_grown >= cfg.debounce && !long_reg)
                begin
                    pend_next  = EV_SHORT;
                    ready_next = 1'b1;
                end
            end
            last_next = pressed;

            if (pressed && !ready_reg && !long_next && held_next >= cfg.long_press)
            begin
                pend_next  = EV_LONG;
                ready_next = 1'b1;
                long_next  = 1'b1;
            end
        end
        else if (read_en)
        begin
            pend_next  = EV_NONE;
            ready_next = 1'b0;
        end
    end

    assign status.ready = ready_next;
    assign status.code  = (read_en && ready_reg) ? pend_reg : EV_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            held_reg  <= '0;
            pend_reg  <= EV_NONE;
            ready_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else
        begin
            last_reg  <= last_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            ready_reg <= ready_next;
            long_reg  <= long_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/kpc_merge.sv]
`default_nettype none

module kpc_merge
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire lane_status_t      status [NUM_KEYS],
    output logic [1:0]             event_code,
    output logic [MASK_W-1:0]      pending_mask
);

    // at most one lane returns a code, so an or merge is enough
    always_comb
    begin
        event_code = EV_NONE;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            event_code = event_code | status[k].code;
        end
    end

    for (genvar k = 0; k < MASK_W; k++)
    begin : g_mask
        if (k < NUM_KEYS)
        begin : g_key
            assign pending_mask[k] = status[k].ready;
        end
        else
        begin : g_none
            assign pending_mask[k] = 1'b0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/key_press_classifier_unit.sv]
// result: a request's result is registered and shows in the cycle after acceptance
// throughput: one request per cycle; on a scan every key lane updates in the same cycle and
//   in_ready only drops while a finished result waits on a stalled output
// reset: asynchronous active low; all keys released, timers zero, no events,
//   registers back to scan period 10, debounce 30, long press 800
`default_nettype none

module key_press_classifier_unit
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration writes
    input  wire logic                 cfg_write_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic [PIN_W-1:0]     pin_levels,
    input  wire logic [IDX_W-1:0]     key_index,

    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                event_code,
    output logic [MASK_W-1:0]         pending_mask
);

    cfg_t cfg_reg;

    logic              in_fire;
    logic              scan_en;
    logic              read_req;

    lane_status_t      status [NUM_KEYS];
    logic [1:0]        code_merged;
    logic [MASK_W-1:0] mask_merged;

    logic              out_valid_reg;
    logic [1:0]        event_code_reg;
    logic [MASK_W-1:0] pending_mask_reg;

    // a new request is taken whenever the result register is empty or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign scan_en  = in_fire && (op == OP_SCAN);
    assign read_req = in_fire && (op == OP_READ);

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_period <= SCAN_PERIOD_RST;
            cfg_reg.debounce    <= DEBOUNCE_RST;
            cfg_reg.long_press  <= LONG_PRESS_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SCAN_PERIOD: cfg_reg.scan_period <= cfg_data[PERIOD_W-1:0];
                REG_DEBOUNCE:    cfg_reg.debounce    <= cfg_data[HELD_W-1:0];
                REG_LONG_PRESS:  cfg_reg.long_press  <= cfg_data[HELD_W-1:0];
                default:         ;
            endcase
        end
    end

    // one lane per key; keys past the pin field always see a released level,
    // and an out-of-range key index matches no lane so a read returns none
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic level;
        logic sel;

        if (k < PIN_W)
        begin : g_pin
            assign level = pin_levels[k];
        end
        else
        begin : g_released
            assign level = 1'b1;
        end

        assign sel = read_req && (key_index == IDX_W'(k));

        kpc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .scan_en   (scan_en),
            .read_en   (sel),
            .pin_level (level),
            .cfg       (cfg_reg),
            .status    (status[k])
        );
    end

    // combine lane results into one code and the post-request pending mask
    kpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .status       (status),
        .event_code   (code_merged),
        .pending_mask (mask_merged)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            event_code_reg   <= code_merged;
            pending_mask_reg <= mask_merged;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_code   = event_code_reg;
    assign pending_mask = pending_mask_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import kpc_pkg::*;

    localparam int KEYS     = 4;
    localparam int HELD_MAX = 65535;
    localparam int REPORT_MAX = 10;

    // one result as the block should return it
    typedef struct {
        ev_code_t              code;
        logic [MASK_W-1:0]     mask;
    } key_result_t;

    // key state tracker plus the queue of results still owed by the block
    class key_event_scoreboard;
        logic [PERIOD_W-1:0] scan_period;
        logic [HELD_W-1:0]   debounce;
        logic [HELD_W-1:0]   long_press;

        bit                  was_pressed [KEYS];
        logic [HELD_W-1:0]   held        [KEYS];
        ev_code_t            latched     [KEYS];
        bit                  unread      [KEYS];
        bit                  long_done   [KEYS];

        key_result_t         awaited_results [$];
        int                  errors;

        function new();
            scan_period = SCAN_PERIOD_RST;
            debounce    = DEBOUNCE_RST;
            long_press  = LONG_PRESS_RST;
            errors      = 0;
            for (int k = 0; k < KEYS; k++) begin
                was_pressed[k] = 1'b0;
                held[k]        = '0;
                latched[k]     = EV_NONE;
                unread[k]      = 1'b0;
                long_done[k]   = 1'b0;
            end
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SCAN_PERIOD: scan_period = value[PERIOD_W-1:0];
                REG_DEBOUNCE:    debounce    = value;
                REG_LONG_PRESS:  long_press  = value;
                default: ;
            endcase
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // advance the key state for one accepted request and queue its result
        function void note_request(logic req_op, logic [PIN_W-1:0] levels,
                                   logic [IDX_W-1:0] idx);
            key_result_t  res;
            bit           pressed;
            int unsigned  grown;

            res.code = EV_NONE;
            if (req_op == OP_SCAN) begin
                for (int k = 0; k < KEYS; k++) begin
                    pressed = (k < PIN_W) ? !levels[k] : 1'b0;
                    if (was_pressed[k]) begin
                        grown   = held[k] + scan_period;
                        held[k] = (grown > HELD_MAX) ? HELD_W'(HELD_MAX) : grown[HELD_W-1:0];
                    end
                    if (pressed && !was_pressed[k]) begin
                        held[k]      = '0;
                        long_done[k] = 1'b0;
                    end else if (!pressed && was_pressed[k]) begin
                        if (held[k] >= debounce && !long_done[k]) begin
                            latched[k] = EV_SHORT;
                            unread[k]  = 1'b1;
                        end
                    end
                    was_pressed[k] = pressed;
                    if (pressed && !unread[k] && !long_done[k] && held[k] >= long_press) begin
                        latched[k]   = EV_LONG;
                        unread[k]    = 1'b1;
                        long_done[k] = 1'b1;
                    end
                end
            end else if (idx < KEYS) begin
                if (unread[idx]) begin
                    res.code     = latched[idx];
                    unread[idx]  = 1'b0;
                    latched[idx] = EV_NONE;
                end
            end

            res.mask = '0;
            for (int k = 0; k < KEYS && k < MASK_W; k++)
                res.mask[k] = unread[k];
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] code, logic [MASK_W-1:0] mask);
            key_result_t want;
            if (awaited_results.size() == 0) begin
                note_error($sformatf("result with nothing outstanding, code %0d mask %h",
                                     code, mask));
                return;
            end
            want = awaited_results.pop_front();
            if (code !== want.code)
                note_error($sformatf("event_code expected %0d got %0d", want.code, code));
            if (mask !== want.mask)
                note_error($sformatf("pending_mask expected %h got %h", want.mask, mask));
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block inputs, all known from time zero
    logic                 cfg_write_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 op           = OP_SCAN;
    logic [PIN_W-1:0]     pin_levels   = '1;
    logic [IDX_W-1:0]     key_index    = '0;
    logic                 out_ready    = 1'b0;

    // block outputs
    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           event_code;
    logic [MASK_W-1:0]    pending_mask;

    // idle percentages for both sides, changed between phases
    int send_idle_pct = 10;
    int recv_idle_pct = 75;

    // pin levels carried from one scan request to the next
    logic [PIN_W-1:0] pin_state = '1;

    key_event_scoreboard sb;

    key_press_classifier_unit #(
        .NUM_KEYS (KEYS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .pin_levels   (pin_levels),
        .key_index    (key_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_code   (event_code),
        .pending_mask (pending_mask)
    );

    // receiver stalls at random, at the rate set for the current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // every result taken by the receiver is checked against the oldest prediction
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(event_code, pending_mask);

    // one request: optional random gap with valid low, then hold until accepted
    task automatic send_request(input logic req_op, input logic [PIN_W-1:0] levels,
                                input logic [IDX_W-1:0] idx);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        op         <= req_op;
        pin_levels <= levels;
        key_index  <= idx;
        do @(posedge clk); while (!in_ready);
        sb.note_request(req_op, levels, idx);
    endtask

    // stop sending and wait until the block owes nothing, then let it settle
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // write all three registers back to back; upper bits of the period word are junk
    task automatic apply_settings(input logic [PERIOD_W-1:0] period,
                                  input logic [HELD_W-1:0] deb,
                                  input logic [HELD_W-1:0] lng);
        logic [CFG_W-1:0] word;
        word = {9'($urandom_range(0, 511)), period};
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_SCAN_PERIOD;
        cfg_data     <= word;
        @(posedge clk);
        sb.set_register(REG_SCAN_PERIOD, word);
        cfg_index    <= REG_DEBOUNCE;
        cfg_data     <= deb;
        @(posedge clk);
        sb.set_register(REG_DEBOUNCE, deb);
        cfg_index    <= REG_LONG_PRESS;
        cfg_data     <= lng;
        @(posedge clk);
        sb.set_register(REG_LONG_PRESS, lng);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // random traffic: key levels change slowly so holds last several scans,
    // with a little noise where all pins jump at once
    task automatic run_random(input int count, input int toggle_pct, input int read_pct,
                              input bit hold_first_key);
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                // mostly real keys, sometimes an index past the last key
                idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(4, 7))
                                                  : IDX_W'($urandom_range(0, KEYS - 1));
                send_request(OP_READ, PIN_W'($urandom_range(0, 15)), idx);
            end else begin
                if ($urandom_range(0, 99) < 5)
                    pin_state = PIN_W'($urandom_range(0, 15));
                else
                    for (int k = 0; k < PIN_W; k++)
                        if ($urandom_range(0, 99) < toggle_pct)
                            pin_state[k] = ~pin_state[k];
                if (hold_first_key)
                    pin_state[0] = 1'b0;
                send_request(OP_SCAN, pin_state, IDX_W'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls a lot
        send_idle_pct = 10;
        recv_idle_pct = 75;

        // reset settings: reads with nothing pending and past the last key
        send_request(OP_READ, 4'hF, 3'd0);
        send_request(OP_READ, 4'h0, 3'd7);
        send_request(OP_READ, 4'h5, 3'd4);
        // all released, then all pressed at once
        send_request(OP_SCAN, 4'hF, 3'd0);
        send_request(OP_SCAN, 4'h0, 3'd7);
        send_request(OP_SCAN, 4'h0, 3'd0);
        send_request(OP_SCAN, 4'h0, 3'd0);
        // keys 0 and 1 let go right at the debounce time: short presses
        send_request(OP_SCAN, 4'b0011, 3'd0);
        send_request(OP_READ, 4'hF, 3'd0);
        // key 0 pressed again, then released too early to count
        send_request(OP_SCAN, 4'b0010, 3'd0);
        send_request(OP_SCAN, 4'b1111, 3'd0);
        send_request(OP_READ, 4'h0, 3'd1);
        send_request(OP_READ, 4'h0, 3'd2);
        send_request(OP_READ, 4'h0, 3'd3);
        send_request(OP_READ, 4'h0, 3'd3);
        send_request(OP_READ, 4'hA, 3'd5);
        send_request(OP_READ, 4'h0, 3'd6);
        pin_state = 4'hF;
        run_random(60, 15, 30, 1'b0);

        // smallest nonzero period and long time, no debounce
        wait_until_drained();
        apply_settings(7'd1, 16'd0, 16'd1);
        // press key 0, long press one scan later, release gives nothing more
        send_request(OP_SCAN, 4'hE, 3'd0);
        send_request(OP_SCAN, 4'hE, 3'd0);
        send_request(OP_SCAN, 4'hF, 3'd0);
        send_request(OP_READ, 4'hF, 3'd0);
        pin_state = 4'hF;
        run_random(60, 30, 30, 1'b0);

        // now the sender idles a lot and the receiver rarely stalls
        send_idle_pct = 75;
        recv_idle_pct = 10;

        // largest period and times: key 0 held through a long stretch
        wait_until_drained();
        apply_settings(7'd127, 16'hFFFF, 16'hFFFF);
        run_random(140, 10, 5, 1'b1);

        // from here on neither side idles
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // zero period and zero times: a press fires long at once
        wait_until_drained();
        apply_settings(7'd0, 16'd0, 16'd0);
        send_request(OP_SCAN, 4'h7, 3'd0);
        send_request(OP_READ, 4'h7, 3'd3);
        pin_state = 4'h7;
        run_random(50, 30, 30, 1'b0);

        // biggest raw period with mid-range times
        wait_until_drained();
        apply_settings(7'd127, 16'd200, 16'd1000);
        run_random(60, 10, 30, 1'b0);

        // a random setting to finish
        wait_until_drained();
        apply_settings(PERIOD_W'($urandom_range(1, 100)), HELD_W'($urandom_range(0, 300)),
                       HELD_W'($urandom_range(1, 1500)));
        run_random(60, 12, 30, 1'b0);

        wait_until_drained();
        repeat (5) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.note_error($sformatf("%0d results never arrived", sb.outstanding()));

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_lane.sv
hw/rtl/kpc_merge.sv
hw/rtl/key_press_classifier_unit.sv
bench/testbench.sv
